FILE: rtl/core/size_filtered_vwap_midprice_defines.svh
// Assertion macros shared by the checker of the size-filtered VWAP midprice block.
// Depends on nothing; expects a clock named i_clk and a reset named i_rst_n in scope.
`ifndef SIZE_FILTERED_VWAP_MIDPRICE_DEFINES_SVH
`define SIZE_FILTERED_VWAP_MIDPRICE_DEFINES_SVH

// Same-cycle implication, held off while in reset
`define SFVM_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while in reset
`define SFVM_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sfvm_pkg.sv
// Shared widths, codes and lane control types for the size-filtered VWAP midprice block.
// No dependencies; used by every module of the block except sfvm_div.
package sfvm_pkg;

    // Field widths
    localparam int PRICE_W = 32;
    localparam int SIZE_W  = 24;
    localparam int SUM_W   = 28;
    localparam int VAL_W   = 60;
    localparam int OUT_W   = 48;
    localparam int CNT_W   = 5;

    // Book depth limit and default fraction bits
    localparam int MAX_LEVELS = 10;
    localparam int FRAC_BITS  = 16;

    // Register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_QTY_CAP = 1'b0;
    localparam logic [SUM_W-1:0] QTY_CAP_RST = SUM_W'(1);

    // Multiply-accumulate chunking in the merge stage
    localparam int MAC_CHUNK_W = 32;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_CHECK,
        ST_AVG,
        ST_MRG,
        ST_PUT
    } t_state;

    // Control into one side lane
    typedef struct packed {
        logic acc_en;
        logic clear;
        logic div_start;
    } t_lane_ctl;

    // Status out of one side lane
    typedef struct packed {
        logic [SUM_W-1:0] size_sum;
        logic             avg_done;
    } t_lane_stat;

endpackage

FILE: rtl/core/sfvm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses no package; dividend must satisfy num < den * 2^Q_W.
module sfvm_div #(
    parameter int DEN_W = 28,
    parameter int Q_W   = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [Q_W+DEN_W-1:0] i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic [Q_W-1:0]     o_quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;

    // One trial subtraction: shift in the next dividend bit
    always_comb begin
        w_trial = {r_rem, r_quo[Q_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: upper dividend bits start as the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[Q_W+DEN_W-1:Q_W];
            r_quo <= i_num[Q_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: rtl/core/sfvm_lane.sv
// One book side: size and value accumulation with stop logic, then its fixed-point average.
// Depends on sfvm_pkg and sfvm_div.
module sfvm_lane #(
    parameter int FRAC_BITS = sfvm_pkg::FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sfvm_pkg::t_lane_ctl                i_ctl,
    input  logic                               i_present,
    input  logic [sfvm_pkg::PRICE_W-1:0]       i_price,
    input  logic [sfvm_pkg::SIZE_W-1:0]        i_size,
    input  logic [sfvm_pkg::SUM_W-1:0]         i_qty_cap,
    output sfvm_pkg::t_lane_stat               o_stat,
    output logic [sfvm_pkg::PRICE_W+FRAC_BITS-1:0] o_avg
);

    localparam int SUM_W  = sfvm_pkg::SUM_W;
    localparam int VAL_W  = sfvm_pkg::VAL_W;
    localparam int AVG_W  = sfvm_pkg::PRICE_W + FRAC_BITS;
    localparam int DVD_W  = VAL_W + FRAC_BITS;
    localparam int PROD_W = sfvm_pkg::PRICE_W + sfvm_pkg::SIZE_W;

    logic [SUM_W-1:0]  r_ssum;
    logic [VAL_W-1:0]  r_vsum;
    logic              r_stopped;

    logic [SUM_W-1:0]  n_ssum;
    logic [VAL_W-1:0]  n_vsum;
    logic [PROD_W-1:0] w_prod;
    logic [DVD_W-1:0]  w_dividend;
    logic              w_div_done;

    // Level add
    always_comb begin
        w_prod = i_price * i_size;
        n_ssum = r_ssum + SUM_W'(i_size);
        n_vsum = r_vsum + VAL_W'(w_prod);
    end

    // Running sums; a side stops on an absent level or once the filter is met
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_ssum    <= '0;
            r_vsum    <= '0;
            r_stopped <= 1'b0;
        end else if (i_ctl.acc_en && !r_stopped) begin
            if (!i_present) begin
                r_stopped <= 1'b1;
            end else begin
                r_ssum <= n_ssum;
                r_vsum <= n_vsum;
                if (n_ssum >= i_qty_cap) begin
                    r_stopped <= 1'b1;
                end
            end
        end
    end

    // Average = floor(value * 2^FRAC_BITS / size)
    assign w_dividend = DVD_W'(r_vsum) << FRAC_BITS;

    sfvm_div #(
        .DEN_W (SUM_W),
        .Q_W   (AVG_W)
    ) u_avg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (w_dividend),
        .i_den   (r_ssum),
        .o_done  (w_div_done),
        .o_quot  (o_avg)
    );

    assign o_stat.size_sum = r_ssum;
    assign o_stat.avg_done = w_div_done;

endmodule

FILE: rtl/core/sfvm_merge.sv
// Merging stage: cross-weights the two side averages and divides by the total size.
// Depends on sfvm_pkg and sfvm_div.
module sfvm_merge #(
    parameter int FRAC_BITS = sfvm_pkg::FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  sfvm_pkg::t_lane_stat                   i_bid,
    input  sfvm_pkg::t_lane_stat                   i_ask,
    input  logic [sfvm_pkg::PRICE_W+FRAC_BITS-1:0] i_avg_bid,
    input  logic [sfvm_pkg::PRICE_W+FRAC_BITS-1:0] i_avg_ask,
    output logic                                   o_done,
    output logic [sfvm_pkg::PRICE_W+FRAC_BITS-1:0] o_price
);

    localparam int SUM_W   = sfvm_pkg::SUM_W;
    localparam int CH_W    = sfvm_pkg::MAC_CHUNK_W;
    localparam int AVG_W   = sfvm_pkg::PRICE_W + FRAC_BITS;
    localparam int DEN_W   = SUM_W + 1;
    localparam int ACC_W   = AVG_W + DEN_W;
    localparam int PROD_W  = CH_W + SUM_W;
    localparam int SHIFT_W = PROD_W + CH_W;

    logic              r_mac_on;
    logic [1:0]        r_step;
    logic              r_prod_v;
    logic              r_prod_hi;
    logic              r_prod_last;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_div_go;

    logic [2*CH_W-1:0]  w_avg_ext;
    logic [CH_W-1:0]    w_chunk;
    logic [SUM_W-1:0]   w_weight;
    logic [SHIFT_W-1:0] w_shifted;
    logic [DEN_W-1:0]   w_total;

    // Operand select: step[1] picks the side, step[0] the 32-bit chunk of its average
    always_comb begin
        w_avg_ext = r_step[1] ? (2*CH_W)'(i_avg_ask) : (2*CH_W)'(i_avg_bid);
        w_chunk   = r_step[0] ? w_avg_ext[2*CH_W-1:CH_W] : w_avg_ext[CH_W-1:0];
        w_weight  = r_step[1] ? i_bid.size_sum : i_ask.size_sum;
        w_shifted = r_prod_hi ? {r_prod, {CH_W{1'b0}}} : SHIFT_W'(r_prod);
        w_total   = DEN_W'(i_bid.size_sum) + DEN_W'(i_ask.size_sum);
    end

    // Sequencer for the four partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_on    <= 1'b0;
            r_step      <= '0;
            r_prod_v    <= 1'b0;
            r_prod_last <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            r_div_go <= r_prod_v && r_prod_last;
            r_prod_v <= r_mac_on;
            if (i_start) begin
                r_mac_on <= 1'b1;
                r_step   <= '0;
            end else if (r_mac_on) begin
                r_step      <= r_step + 2'd1;
                r_prod_last <= (r_step == 2'b11);
                if (r_step == 2'b11) begin
                    r_mac_on <= 1'b0;
                end
            end
        end
    end

    // Product register, then accumulate
    always_ff @(posedge i_clk) begin
        if (r_mac_on) begin
            r_prod    <= w_chunk * w_weight;
            r_prod_hi <= r_step[0];
        end
        if (i_start) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(w_shifted);
        end
    end

    sfvm_div #(
        .DEN_W (DEN_W),
        .Q_W   (AVG_W)
    ) u_mix_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_acc),
        .i_den   (w_total),
        .o_done  (o_done),
        .o_quot  (o_price)
    );

endmodule

FILE: rtl/core/size_filtered_vwap_midprice.sv
// Size-filtered VWAP midprice: takes a book snapshot one level pair per item and gives one
// result per snapshot, a weighted price or the fallback best prices. A level item that is not
// the last is taken at once while the block accumulates. The last item holds the input until
// the result is loaded. When both sides carry size, both side averages run together on
// bit-serial dividers, one bit per cycle, then four partial products are summed and a third
// bit-serial divider forms the final price; when either side is empty the sequencer goes
// straight from the check state to the put state. The result waits in an output register,
// so level items of the next snapshot are taken while it is held. The size cap sits at byte 0.
// Depends on sfvm_pkg, sfvm_lane, sfvm_merge and sfvm_div.
module size_filtered_vwap_midprice #(
    parameter int FRAC_BITS = sfvm_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfvm_pkg::PADDR_W-1:0]        paddr,
    input  logic [sfvm_pkg::PDATA_W-1:0]        pwdata,
    output logic [sfvm_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // Level items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_bid_present,
    input  logic [sfvm_pkg::PRICE_W-1:0]        i_bid_price,
    input  logic [sfvm_pkg::SIZE_W-1:0]         i_bid_size,
    input  logic                                i_ask_present,
    input  logic [sfvm_pkg::PRICE_W-1:0]        i_ask_price,
    input  logic [sfvm_pkg::SIZE_W-1:0]         i_ask_size,
    input  logic [sfvm_pkg::PRICE_W-1:0]        i_best_bid,
    input  logic [sfvm_pkg::PRICE_W-1:0]        i_best_ask,
    input  logic                                i_last_level,
    // Result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sfvm_pkg::OUT_W-1:0]          o_bid_out,
    output logic [sfvm_pkg::OUT_W-1:0]          o_ask_out,
    output logic                                o_vwap_used
);

    localparam int SUM_W = sfvm_pkg::SUM_W;
    localparam int CNT_W = sfvm_pkg::CNT_W;
    localparam int OUT_W = sfvm_pkg::OUT_W;
    localparam int AVG_W = sfvm_pkg::PRICE_W + FRAC_BITS;

    sfvm_pkg::t_state r_state, n_state;

    logic [SUM_W-1:0]            r_qty_cap;
    logic [CNT_W-1:0]            r_level_cnt;
    logic [sfvm_pkg::PRICE_W-1:0] r_best_bid;
    logic [sfvm_pkg::PRICE_W-1:0] r_best_ask;
    logic                        r_out_valid;
    logic [OUT_W-1:0]            r_bid_out;
    logic [OUT_W-1:0]            r_ask_out;
    logic                        r_vwap_used;
    logic                        r_use_vwap;
    logic                        n_use_vwap;

    logic                 w_accept;
    logic                 w_level_ok;
    logic                 w_load;
    logic                 w_both_sized;
    logic                 w_div_start;
    logic                 w_merge_start;
    logic                 w_merge_done;
    logic                 w_cfg_wr;
    logic [AVG_W-1:0]     w_avg_bid;
    logic [AVG_W-1:0]     w_avg_ask;
    logic [AVG_W-1:0]     w_price;
    sfvm_pkg::t_lane_ctl  w_lane_ctl;
    sfvm_pkg::t_lane_stat w_bid_stat;
    sfvm_pkg::t_lane_stat w_ask_stat;

    // Configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qty_cap <= sfvm_pkg::QTY_CAP_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                sfvm_pkg::REG_QTY_CAP: r_qty_cap <= pwdata[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sfvm_pkg::REG_QTY_CAP: prdata = sfvm_pkg::PDATA_W'(r_qty_cap);
            default:               prdata = '0;
        endcase
    end

    // Input handshake and level count
    assign o_in_stall   = (r_state != sfvm_pkg::ST_ACC);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_level_ok   = (r_level_cnt < CNT_W'(sfvm_pkg::MAX_LEVELS));
    assign w_load       = (r_state == sfvm_pkg::ST_PUT) && (!r_out_valid || !i_out_stall);
    assign w_both_sized = (w_bid_stat.size_sum != '0) && (w_ask_stat.size_sum != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load) begin
            r_level_cnt <= '0;
        end else if (w_accept && w_level_ok) begin
            r_level_cnt <= r_level_cnt + CNT_W'(1);
        end
    end

    // Fallback prices are taken from the last item of the snapshot
    always_ff @(posedge i_clk) begin
        if (w_accept && i_last_level) begin
            r_best_bid <= i_best_bid;
            r_best_ask <= i_best_ask;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sfvm_pkg::ST_ACC;
            r_use_vwap <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_use_vwap <= n_use_vwap;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_use_vwap    = r_use_vwap;
        w_div_start   = 1'b0;
        w_merge_start = 1'b0;
        unique case (r_state)
            sfvm_pkg::ST_ACC: begin
                if (w_accept && i_last_level) begin
                    n_state = sfvm_pkg::ST_CHECK;
                end
            end
            sfvm_pkg::ST_CHECK: begin
                n_use_vwap = w_both_sized;
                if (w_both_sized) begin
                    w_div_start = 1'b1;
                    n_state     = sfvm_pkg::ST_AVG;
                end else begin
                    n_state = sfvm_pkg::ST_PUT;
                end
            end
            sfvm_pkg::ST_AVG: begin
                // both lanes run the same number of steps
                if (w_bid_stat.avg_done) begin
                    w_merge_start = 1'b1;
                    n_state       = sfvm_pkg::ST_MRG;
                end
            end
            sfvm_pkg::ST_MRG: begin
                if (w_merge_done) begin
                    n_state = sfvm_pkg::ST_PUT;
                end
            end
            sfvm_pkg::ST_PUT: begin
                if (w_load) begin
                    n_state = sfvm_pkg::ST_ACC;
                end
            end
            default: n_state = sfvm_pkg::ST_ACC;
        endcase
    end

    // Lanes
    assign w_lane_ctl.acc_en    = w_accept && w_level_ok;
    assign w_lane_ctl.clear     = w_load;
    assign w_lane_ctl.div_start = w_div_start;

    sfvm_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_bid_lane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_lane_ctl),
        .i_present (i_bid_present),
        .i_price   (i_bid_price),
        .i_size    (i_bid_size),
        .i_qty_cap (r_qty_cap),
        .o_stat    (w_bid_stat),
        .o_avg     (w_avg_bid)
    );

    sfvm_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ask_lane (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_lane_ctl),
        .i_present (i_ask_present),
        .i_price   (i_ask_price),
        .i_size    (i_ask_size),
        .i_qty_cap (r_qty_cap),
        .o_stat    (w_ask_stat),
        .o_avg     (w_avg_ask)
    );

    // Merge
    sfvm_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_merge_start),
        .i_bid     (w_bid_stat),
        .i_ask     (w_ask_stat),
        .i_avg_bid (w_avg_bid),
        .i_avg_ask (w_avg_ask),
        .o_done    (w_merge_done),
        .o_price   (w_price)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_vwap_used <= r_use_vwap;
            if (r_use_vwap) begin
                r_bid_out <= OUT_W'(w_price);
                r_ask_out <= OUT_W'(w_price);
            end else begin
                r_bid_out <= OUT_W'(r_best_bid) << FRAC_BITS;
                r_ask_out <= OUT_W'(r_best_ask) << FRAC_BITS;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bid_out   = r_bid_out;
    assign o_ask_out   = r_ask_out;
    assign o_vwap_used = r_vwap_used;

endmodule

FILE: rtl/core/sfvm_chk.sv
// Port-level checker for the size-filtered VWAP midprice block, bound to the top level.
// Depends on sfvm_pkg and size_filtered_vwap_midprice_defines.svh.
`include "size_filtered_vwap_midprice_defines.svh"

module sfvm_chk #(
    parameter int FRAC_BITS = sfvm_pkg::FRAC_BITS
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       i_last_level,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [sfvm_pkg::OUT_W-1:0] o_bid_out,
    input logic [sfvm_pkg::OUT_W-1:0] o_ask_out,
    input logic                       o_vwap_used
);

    // A stalled result item holds
    `SFVM_AST_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_bid_out) && $stable(o_ask_out) && $stable(o_vwap_used), "result changed while stalled")

    // Weighted result carries one price on both sides
    `SFVM_AST_IMP(a_vwap_same, o_out_valid && o_vwap_used, o_bid_out == o_ask_out, "weighted bid and ask differ")

    // Fallback prices are whole ticks
    `SFVM_AST_IMP(a_fallback_whole, o_out_valid && !o_vwap_used, ((o_bid_out >> FRAC_BITS) << FRAC_BITS) == o_bid_out && ((o_ask_out >> FRAC_BITS) << FRAC_BITS) == o_ask_out, "fallback has fraction bits")

    // Closing a snapshot holds off the next item
    `SFVM_AST_NEXT(a_last_stalls, i_in_valid && !o_in_stall && i_last_level, o_in_stall, "input not held after last level")

    // A fresh result follows a snapshot close
    `SFVM_AST_IMP(a_result_cause, $rose(o_out_valid), $past(o_in_stall), "result without a closed snapshot")

endmodule

bind size_filtered_vwap_midprice sfvm_chk #(
    .FRAC_BITS (FRAC_BITS)
) u_sfvm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_last_level (i_last_level),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_bid_out    (o_bid_out),
    .o_ask_out    (o_ask_out),
    .o_vwap_used  (o_vwap_used)
);
